>>> src/cvtr_pkg.sv
package cvtr_pkg;

    // Volume geometry limits
    localparam int VOLUME_ENTRIES = 65536;
    localparam int MAX_DIM        = 1024;
    localparam int MAX_LABELS     = 256;
    localparam int MAX_AXIS       = (MAX_DIM > MAX_LABELS) ? MAX_DIM : MAX_LABELS;

    localparam int ADDR_W = $clog2(VOLUME_ENTRIES);

    // Fixed field widths of the channels and the configuration port
    localparam int LOAD_IDX_W = 16;
    localparam int VALUE_W    = 16;
    localparam int COORD_W    = 10;
    localparam int LABEL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_LBL_W  = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREV_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_LABELS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_LABELS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_PRESENT = 3'd6;

    // Request modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Q1.8 weights
    localparam int WGT_FRAC = 8;
    localparam int WGT_W    = WGT_FRAC + 1;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1 << WGT_FRAC);

    // Axis mapping unit
    localparam int AX_P_W   = $clog2(MAX_AXIS + 1);
    localparam int AX_T_W   = COORD_W;
    localparam int AX_N_W   = AX_P_W + ((AX_T_W > AX_P_W) ? AX_T_W : AX_P_W);
    localparam int AX_Q_W   = $clog2(MAX_AXIS) + WGT_FRAC;
    localparam int DIV_RADIX_BITS = 3;
    localparam int DIV_STEPS = (AX_Q_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_BITS  = DIV_STEPS * DIV_RADIX_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int REM_W     = AX_P_W;

    // Address arithmetic
    localparam int ROW_W       = 2 * AX_P_W;
    localparam int STRIDE_W    = 2 * AX_P_W;
    localparam int FULL_ADDR_W = ROW_W + AX_P_W + 1;

    // Corner code {dy, dx, dr}
    localparam int CORNERS   = 8;
    localparam int CORNER_W  = 3;
    localparam int CORNER_DR = 0;
    localparam int CORNER_DX = 1;
    localparam int CORNER_DY = 2;

    // Accumulator
    localparam int W2_W   = 2 * WGT_FRAC + 1;
    localparam int W3_W   = 3 * WGT_FRAC + 1;
    localparam int PROD_W = VALUE_W + W3_W + 1;
    localparam int ACC_W  = PROD_W + CORNER_W;

    localparam logic signed [VALUE_W-1:0] COST_NEG_ONE = VALUE_W'(-4096);

    typedef struct packed {
        logic [AX_P_W-1:0] base;
        logic [WGT_W-1:0]  wup;
    } t_axis_res;

    typedef struct packed {
        logic                   vld;
        logic [CORNER_W-1:0]    corner;
        logic [FULL_ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic                       vld;
        logic [CORNER_W-1:0]        corner;
        logic signed [VALUE_W-1:0]  data;
    } t_rd_rsp;

    typedef struct packed {
        logic                       vld;
        logic signed [VALUE_W-1:0]  value;
    } t_mac_res;

endpackage

>>> src/cvtr_ifs.sv
interface cvtr_in_if import cvtr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [LOAD_IDX_W-1:0]     load_index;
    logic signed [VALUE_W-1:0] load_value;
    logic [COORD_W-1:0]        target_x;
    logic [COORD_W-1:0]        target_y;
    logic [LABEL_W-1:0]        target_label;

    modport source (
        output valid, mode, load_index, load_value, target_x, target_y, target_label,
        input  ready
    );
    modport sink (
        input  valid, mode, load_index, load_value, target_x, target_y, target_label,
        output ready
    );
endinterface

interface cvtr_out_if import cvtr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] cost_out;

    modport source (output valid, cost_out, input ready);
    modport sink (input valid, cost_out, output ready);
endinterface

>>> src/cvtr_axis.sv
module cvtr_axis import cvtr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [AX_T_W-1:0] i_target,
    input  logic [AX_P_W-1:0] i_prev,
    input  logic [AX_P_W-1:0] i_new,
    output logic              o_done,
    output t_axis_res         o_res
);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_CMP, A_DIV} t_state;

    t_state                         r_state;
    logic                           r_done;
    t_axis_res                      r_res;
    logic [AX_T_W-1:0]              r_t;
    logic [AX_N_W-1:0]              r_n;
    logic [AX_N_W-1:0]              r_lim;
    logic [REM_W-1:0]               r_rem;
    logic [REM_W-1:0]               n_rem;
    logic [DIV_BITS-1:0]            r_dq;
    logic [DIV_BITS-1:0]            n_dq;
    logic [DIV_CNT_W-1:0]           r_cnt;
    logic [REM_W:0]                 trial;
    logic [AX_N_W+WGT_FRAC-1:0]     dividend;

    assign dividend = {r_n, {WGT_FRAC{1'b0}}};

    // Restoring division, DIV_RADIX_BITS quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_dq  = r_dq;
        trial = '0;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            trial = {n_rem, n_dq[DIV_BITS-1]};
            n_dq  = {n_dq[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, i_new}) begin
                trial   = trial - {1'b0, i_new};
                n_dq[0] = 1'b1;
            end
            n_rem = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_t     <= i_target;
                        r_done  <= 1'b0;
                        r_state <= A_MUL;
                    end
                end
                A_MUL: begin
                    r_n     <= AX_N_W'(r_t) * AX_N_W'(i_prev);
                    r_lim   <= AX_N_W'(i_prev - 1'b1) * AX_N_W'(i_new);
                    r_state <= A_CMP;
                end
                A_CMP: begin
                    if (r_n >= r_lim) begin
                        // far edge: upper neighbor takes the full weight
                        r_res.base <= i_prev - AX_P_W'(2);
                        r_res.wup  <= WGT_ONE;
                        r_done     <= 1'b1;
                        r_state    <= A_IDLE;
                    end else begin
                        r_rem   <= REM_W'(dividend >> DIV_BITS);
                        r_dq    <= DIV_BITS'(dividend);
                        r_cnt   <= '0;
                        r_state <= A_DIV;
                    end
                end
                A_DIV: begin
                    r_rem <= n_rem;
                    r_dq  <= n_dq;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_res.base <= AX_P_W'(n_dq >> WGT_FRAC);
                        r_res.wup  <= {1'b0, n_dq[WGT_FRAC-1:0]};
                        r_done     <= 1'b1;
                        r_state    <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> src/cvtr_store.sv
module cvtr_store import cvtr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [VALUE_W-1:0] i_wdata,
    input  t_rd_req            i_req,
    output t_rd_rsp            o_rsp
);

    logic [VALUE_W-1:0]  r_mem [VOLUME_ENTRIES];
    logic [VALUE_W-1:0]  r_rdata;
    logic                r_vld;
    logic                r_inr;
    logic [CORNER_W-1:0] r_corner;
    logic                req_inr;

    assign req_inr = i_req.addr < FULL_ADDR_W'(VOLUME_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_req.vld) begin
            r_rdata <= r_mem[i_req.addr[ADDR_W-1:0]];
        end
        r_inr    <= req_inr;
        r_corner <= i_req.corner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req.vld;
        end
    end

    // Neighbors past the end of the memory read as zero
    assign o_rsp.vld    = r_vld;
    assign o_rsp.corner = r_corner;
    assign o_rsp.data   = r_inr ? r_rdata : '0;

endmodule

>>> src/cvtr_mac.sv
module cvtr_mac import cvtr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic [WGT_W-1:0] i_wx,
    input  logic [WGT_W-1:0] i_wy,
    input  logic [WGT_W-1:0] i_wr,
    input  t_rd_rsp          i_rsp,
    output t_mac_res         o_res
);

    logic [WGT_W-1:0]          fx;
    logic [WGT_W-1:0]          fy;
    logic [WGT_W-1:0]          fr;
    logic                      r_s1_vld, r_s1_last;
    logic                      r_s2_vld, r_s2_last;
    logic                      r_s3_vld, r_s3_last;
    logic                      r_done;
    logic [W2_W-1:0]           r_wxy;
    logic [WGT_W-1:0]          r_fr;
    logic [W3_W-1:0]           r_w;
    logic signed [VALUE_W-1:0] r_v1;
    logic signed [VALUE_W-1:0] r_v2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    // Select upper or lower weight per axis from the corner code
    always_comb begin
        fx = i_rsp.corner[CORNER_DX] ? i_wx : WGT_ONE - i_wx;
        fy = i_rsp.corner[CORNER_DY] ? i_wy : WGT_ONE - i_wy;
        fr = i_rsp.corner[CORNER_DR] ? i_wr : WGT_ONE - i_wr;
    end

    always_ff @(posedge i_clk) begin
        r_wxy  <= W2_W'(fx) * W2_W'(fy);
        r_fr   <= fr;
        r_v1   <= i_rsp.data;
        r_w    <= W3_W'(r_wxy) * W3_W'(r_fr);
        r_v2   <= r_v1;
        r_prod <= PROD_W'(r_v2) * PROD_W'($signed({1'b0, r_w}));
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_s3_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld  <= i_rsp.vld;
            r_s1_last <= i_rsp.corner == CORNER_W'(CORNERS - 1);
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
            r_s3_vld  <= r_s2_vld;
            r_s3_last <= r_s2_last;
            r_done    <= r_s3_vld && r_s3_last;
        end
    end

    // Dropping the low bits of the Q3.12 x Q1.8^3 sum floors the result
    assign o_res.vld   = r_done;
    assign o_res.value = r_acc[3*WGT_FRAC +: VALUE_W];

endmodule

>>> src/cost_volume_trilinear_resample.sv
// A load is taken while idle and loads may follow back to back. A query answers once its axis
// mappers, eight neighbor reads and the accumulator are through, and the next request is taken
// only after its answer is in the output register; when all three axes clamp at the far edge the
// divider is skipped. Without a coarse volume the answer goes straight to the done state. The
// 3-bit-per-cycle axis divider and the eight reads through the one memory port set the query time.
// Reset (synchronous, active low) restores register defaults; the memory is not cleared.
module cost_volume_trilinear_resample import cvtr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cvtr_in_if.sink               i_req,
    cvtr_out_if.source            o_rsp
);

    typedef enum logic [2:0] {S_IDLE, S_MAP, S_BASE, S_RUN, S_WAIT, S_DONE} t_state;

    // Configuration registers
    logic [CFG_DIM_W-1:0] r_prev_width;
    logic [CFG_DIM_W-1:0] r_prev_height;
    logic [CFG_LBL_W-1:0] r_prev_labels;
    logic [CFG_DIM_W-1:0] r_new_width;
    logic [CFG_DIM_W-1:0] r_new_height;
    logic [CFG_LBL_W-1:0] r_new_labels;
    logic                 r_present;

    // Sizes after clamping into their legal ranges
    logic [AX_P_W-1:0] pw, ph, pl, nw, nh, nl;

    t_state                    r_state;
    logic [CORNER_W-1:0]       r_cnt;
    logic [ROW_W-1:0]          r_row;
    logic [STRIDE_W-1:0]       r_stride;
    logic [FULL_ADDR_W-1:0]    r_base;
    t_rd_req                   r_a_req;
    logic signed [VALUE_W-1:0] r_res;
    logic                      r_out_vld;
    logic signed [VALUE_W-1:0] r_out_data;

    logic                   in_acc;
    logic                   st_we;
    logic                   ax_start;
    logic                   ax_done_x, ax_done_y, ax_done_r;
    logic                   ax_all_done;
    t_axis_res              ax_x, ax_y, ax_r;
    logic [FULL_ADDR_W-1:0] addr_next;
    t_rd_rsp                st_rsp;
    t_mac_res               mac_res;

    function automatic logic [AX_P_W-1:0] fit_size(input logic [CFG_DATA_W-1:0] v,
                                                   input int lo, input int hi);
        if (int'(v) < lo) begin
            return AX_P_W'(lo);
        end else if (int'(v) > hi) begin
            return AX_P_W'(hi);
        end
        return AX_P_W'(v);
    endfunction

    always_comb begin
        pw = fit_size(CFG_DATA_W'(r_prev_width), 2, MAX_DIM);
        ph = fit_size(CFG_DATA_W'(r_prev_height), 2, MAX_DIM);
        pl = fit_size(CFG_DATA_W'(r_prev_labels), 2, MAX_LABELS);
        nw = fit_size(CFG_DATA_W'(r_new_width), 1, MAX_DIM);
        nh = fit_size(CFG_DATA_W'(r_new_height), 1, MAX_DIM);
        nl = fit_size(CFG_DATA_W'(r_new_labels), 1, MAX_LABELS);
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_width  <= CFG_DIM_W'(2);
            r_prev_height <= CFG_DIM_W'(2);
            r_prev_labels <= CFG_LBL_W'(32);
            r_new_width   <= CFG_DIM_W'(1);
            r_new_height  <= CFG_DIM_W'(1);
            r_new_labels  <= CFG_LBL_W'(64);
            r_present     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PREV_WIDTH:   r_prev_width  <= i_cfg_data[CFG_DIM_W-1:0];
                REG_PREV_HEIGHT:  r_prev_height <= i_cfg_data[CFG_DIM_W-1:0];
                REG_PREV_LABELS:  r_prev_labels <= i_cfg_data[CFG_LBL_W-1:0];
                REG_NEW_WIDTH:    r_new_width   <= i_cfg_data[CFG_DIM_W-1:0];
                REG_NEW_HEIGHT:   r_new_height  <= i_cfg_data[CFG_DIM_W-1:0];
                REG_NEW_LABELS:   r_new_labels  <= i_cfg_data[CFG_LBL_W-1:0];
                REG_PREV_PRESENT: r_present     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Take requests only between queries; a finished result may still wait
    // in the output register while the next request comes in.
    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;

    // Loads write straight into the volume memory; out-of-range indexes drop
    assign st_we = in_acc && (i_req.mode == MODE_LOAD)
                   && (int'(i_req.load_index) < VOLUME_ENTRIES);

    // Kick off the three axis mappers for a query against a present volume
    assign ax_start = in_acc && (i_req.mode == MODE_QUERY) && r_present;

    cvtr_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ax_start),
        .i_target (i_req.target_x),
        .i_prev   (pw),
        .i_new    (nw),
        .o_done   (ax_done_x),
        .o_res    (ax_x)
    );

    cvtr_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ax_start),
        .i_target (i_req.target_y),
        .i_prev   (ph),
        .i_new    (nh),
        .o_done   (ax_done_y),
        .o_res    (ax_y)
    );

    cvtr_axis u_axis_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ax_start),
        .i_target (AX_T_W'(i_req.target_label)),
        .i_prev   (pl),
        .i_new    (nl),
        .o_done   (ax_done_r),
        .o_res    (ax_r)
    );

    assign ax_all_done = ax_done_x && ax_done_y && ax_done_r;

    // Neighbor address: base corner plus one row (dy), one column (dx) and
    // one label (dr) step, picked by the corner counter.
    assign addr_next = r_base
                     + (r_cnt[CORNER_DY] ? FULL_ADDR_W'(r_stride) : '0)
                     + (r_cnt[CORNER_DX] ? FULL_ADDR_W'(pl) : '0)
                     + FULL_ADDR_W'(r_cnt[CORNER_DR]);

    cvtr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (ADDR_W'(i_req.load_index)),
        .i_wdata (i_req.load_value),
        .i_req   (r_a_req),
        .o_rsp   (st_rsp)
    );

    cvtr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (ax_start),
        .i_wx    (ax_x.wup),
        .i_wy    (ax_y.wup),
        .i_wr    (ax_r.wup),
        .i_rsp   (st_rsp),
        .o_res   (mac_res)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_a_req.vld <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_a_req.vld <= 1'b0;
            // Drop the result once the sink takes it; the done state refills
            // the register on its own
            if (r_out_vld && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req.mode == MODE_QUERY)) begin
                        if (r_present) begin
                            r_state <= S_MAP;
                        end else begin
                            r_res   <= COST_NEG_ONE;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MAP: begin
                    // Wait for all three axes, then form the row offset
                    if (ax_all_done) begin
                        r_row    <= ROW_W'(ax_y.base) * ROW_W'(pw) + ROW_W'(ax_x.base);
                        r_stride <= STRIDE_W'(pw) * STRIDE_W'(pl);
                        r_state  <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_base  <= FULL_ADDR_W'(r_row) * FULL_ADDR_W'(pl)
                             + FULL_ADDR_W'(ax_r.base);
                    r_cnt   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    // Issue one neighbor read per cycle
                    r_a_req.vld    <= 1'b1;
                    r_a_req.corner <= r_cnt;
                    r_a_req.addr   <= addr_next;
                    r_cnt          <= r_cnt + 1'b1;
                    if (r_cnt == CORNER_W'(CORNERS - 1)) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mac_res.vld) begin
                        r_res   <= mac_res.value;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.cost_out = r_out_data;

    // A finished sum only arrives while the sequencer waits for it
    a_mac_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_res.vld |-> (r_state == S_WAIT))
        else $error("accumulator result outside wait state");

    // A load never lands on a cycle with a neighbor read in flight
    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> !r_a_req.vld)
        else $error("memory write collides with neighbor read");

    // Reads are issued only from the run state
    a_read_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_req.vld |-> ($past(r_state) == S_RUN))
        else $error("neighbor read outside run state");

    // Weights stay valid while reads and accumulation are under way
    a_weights_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_WAIT) |-> ax_all_done)
        else $error("axis weights lost during accumulation");

    // Without a coarse volume a query answers minus one right away
    a_absent_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req.mode == MODE_QUERY) && !r_present)
        |=> (r_state == S_DONE && r_res == COST_NEG_ONE))
        else $error("absent volume did not answer minus one");

endmodule
